// ----- src/fbpa_pkg.sv -----
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// no dependencies; used by fbpa_ctrl, fbpa_dp and fixed_block_pool_allocator
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int NUM_W     = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int LIM_W     = ADDR_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDR = 2'd0,
        CFG_BLK_BYTES = 2'd1,
        CFG_BLK_COUNT = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT,
        ST_SCAN,
        ST_AMUL,
        ST_AADD,
        ST_LMUL,
        ST_RANGE,
        ST_DIV,
        ST_FSET,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init_map;
        logic scan_step;
        logic mul_idx;
        logic mul_cnt;
        logic alloc_commit;
        logic div_start;
        logic div_step;
        logic free_commit;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  scan_end;
        logic  scan_hit;
        logic  in_range;
        logic  div_done;
        logic  out_full;
    } status_t;

endpackage

`default_nettype wire

// ----- src/fixed_block_pool_allocator.sv -----
// fixed_block_pool_allocator: top level, configuration registers and stream ports
// depends on fbpa_pkg, fbpa_ctrl and fbpa_dp
`default_nettype none

// Usage
//   one request beat in on s_*, one result beat out on m_* for every request.
//   s_tuser carries the operation: init pool, allocate block, free block
//   (the fourth code does nothing and answers address 0, ok 0).
//   s_tdata carries the address to release, used by free only.
//   m_tdata carries the allocated address (0 unless an allocation succeeds),
//   m_tuser carries ok.
//   base address, block size and block count are written on the cfg_* port
//   while no request is in flight; every request reads them as they stand.
// Sequencing, from the accept edge to the result beat
//   one request at a time; s_tready is high only while the sequencer is idle.
//   init: dispatch, map init, done; unused code: dispatch, done
//   allocate: dispatch, a scan of the free map (one map bit per cycle),
//   index multiply, address add, done; a full pool goes from the scan to done
//   free: dispatch, count multiply, range check, the 32-step serial divider,
//   map set, done; a rejected address goes from the range check to done
// Reset clears the registers and marks every block as taken.
// A stalled m_tready holds the result in the output register; the next
// request is still accepted and runs, and waits only to hand its result over.

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // address
    input  wire logic [1:0]                      s_tuser,   // mode
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // block_address
    output logic                                 m_tuser,   // ok
    // register writes
    input  wire logic                            cfg_wen,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_wdata
);

    logic [fbpa_pkg::ADDR_W-1:0] base_addr_reg;
    logic [fbpa_pkg::SIZE_W-1:0] blk_bytes_reg;
    logic [fbpa_pkg::NUM_W-1:0]  blk_count_reg;

    fbpa_pkg::cmd_t    cmd;
    fbpa_pkg::status_t status;

    // register file, write only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg <= '0;
            blk_bytes_reg <= '0;
            blk_count_reg <= '0;
        end else if (cfg_wen) begin
            unique case (fbpa_pkg::cfg_index_t'(cfg_index))
                fbpa_pkg::CFG_BASE_ADDR: base_addr_reg <= cfg_wdata;
                fbpa_pkg::CFG_BLK_BYTES: blk_bytes_reg <= cfg_wdata[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_BLK_COUNT: blk_count_reg <= cfg_wdata[fbpa_pkg::NUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    fbpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // free map, arithmetic and output register
    fbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_tuser),
        .s_address       (s_tdata),
        .base_addr       (base_addr_reg),
        .blk_bytes       (blk_bytes_reg),
        .blk_count       (blk_count_reg),
        .cmd             (cmd),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_block_address (m_tdata),
        .m_ok            (m_tuser)
    );

endmodule

`default_nettype wire

// ----- src/fbpa_ctrl.sv -----
// fbpa_ctrl: sequencer of the pool allocator, one item at a time
// depends on fbpa_pkg
`default_nettype none

module fbpa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire fbpa_pkg::status_t status,
    output fbpa_pkg::cmd_t        cmd
);

    fbpa_pkg::state_t state_reg;
    fbpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fbpa_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = fbpa_pkg::ST_DISPATCH;
            end
            fbpa_pkg::ST_DISPATCH: begin
                unique case (status.mode)
                    fbpa_pkg::MODE_INIT:  state_next = fbpa_pkg::ST_INIT;
                    fbpa_pkg::MODE_ALLOC: state_next = fbpa_pkg::ST_SCAN;
                    fbpa_pkg::MODE_FREE:  state_next = fbpa_pkg::ST_LMUL;
                    default:              state_next = fbpa_pkg::ST_DONE;
                endcase
            end
            fbpa_pkg::ST_INIT:  state_next = fbpa_pkg::ST_DONE;
            fbpa_pkg::ST_SCAN: begin
                if (status.scan_end) state_next = fbpa_pkg::ST_DONE;
                else if (status.scan_hit) state_next = fbpa_pkg::ST_AMUL;
            end
            fbpa_pkg::ST_AMUL:  state_next = fbpa_pkg::ST_AADD;
            fbpa_pkg::ST_AADD:  state_next = fbpa_pkg::ST_DONE;
            fbpa_pkg::ST_LMUL:  state_next = fbpa_pkg::ST_RANGE;
            fbpa_pkg::ST_RANGE: begin
                state_next = status.in_range ? fbpa_pkg::ST_DIV : fbpa_pkg::ST_DONE;
            end
            fbpa_pkg::ST_DIV: begin
                if (status.div_done) state_next = fbpa_pkg::ST_FSET;
            end
            fbpa_pkg::ST_FSET:  state_next = fbpa_pkg::ST_DONE;
            fbpa_pkg::ST_DONE: begin
                if (!status.out_full) state_next = fbpa_pkg::ST_IDLE;
            end
            default: state_next = fbpa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            fbpa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            fbpa_pkg::ST_INIT:  cmd.init_map = 1'b1;
            fbpa_pkg::ST_SCAN: begin
                cmd.scan_step = !status.scan_end && !status.scan_hit;
            end
            fbpa_pkg::ST_AMUL:  cmd.mul_idx = 1'b1;
            fbpa_pkg::ST_AADD:  cmd.alloc_commit = 1'b1;
            fbpa_pkg::ST_LMUL:  cmd.mul_cnt = 1'b1;
            fbpa_pkg::ST_RANGE: cmd.div_start = status.in_range;
            fbpa_pkg::ST_DIV:   cmd.div_step = !status.div_done;
            fbpa_pkg::ST_FSET:  cmd.free_commit = 1'b1;
            fbpa_pkg::ST_DONE:  cmd.out_load = !status.out_full;
            default: begin
            end
        endcase
    end

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("fbpa_ctrl: second beat taken while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_full)
        else $error("fbpa_ctrl: result loaded over a pending beat");

    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !status.div_done)
        else $error("fbpa_ctrl: divider stepped past its last bit");

endmodule

`default_nettype wire

// ----- src/fbpa_dp.sv -----
// fbpa_dp: free map, scan counter, multiplier, serial divider and output stage
// depends on fbpa_pkg
`default_nettype none

module fbpa_dp #(
    parameter int MAX_BLOCKS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [fbpa_pkg::MODE_W-1:0]   s_mode,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]   s_address,
    input  wire logic [fbpa_pkg::ADDR_W-1:0]   base_addr,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]   blk_bytes,
    input  wire logic [fbpa_pkg::NUM_W-1:0]    blk_count,
    input  wire fbpa_pkg::cmd_t                cmd,
    output fbpa_pkg::status_t                  status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fbpa_pkg::ADDR_W-1:0]        m_block_address,
    output logic                               m_ok
);

    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PROD_W = fbpa_pkg::SIZE_W + CNT_W;
    localparam int ADDR_W = fbpa_pkg::ADDR_W;
    localparam int SIZE_W = fbpa_pkg::SIZE_W;
    localparam int LIM_W  = fbpa_pkg::LIM_W;

    logic [MAX_BLOCKS-1:0]           free_map_reg;
    fbpa_pkg::mode_t                 mode_reg;
    logic [ADDR_W-1:0]               addr_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic [SIZE_W-1:0]               rem_reg;
    logic [ADDR_W-1:0]               quo_reg;
    logic [fbpa_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [ADDR_W-1:0]               res_addr_reg;
    logic                            res_ok_reg;
    logic                            m_valid_reg;
    logic [ADDR_W-1:0]               m_addr_reg;
    logic                            m_ok_reg;

    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   mul_op;
    logic [PROD_W-1:0]  product;
    logic [LIM_W-1:0]   limit;
    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    trial_diff;
    logic               trial_take;
    logic               quo_ok;
    logic               scan_end;

    // configured block count, saturated at the pool capacity
    assign cnt = (32'(blk_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blk_count);

    assign scan_end = (idx_reg >= cnt);
    assign mul_op   = cmd.mul_cnt ? cnt : idx_reg;
    assign product  = PROD_W'(blk_bytes) * PROD_W'(mul_op);

    // free range end, one bit wider so it never wraps
    assign limit = LIM_W'(base_addr) + LIM_W'(prod_reg);

    // restoring divide, one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial_take = (trial >= {1'b0, blk_bytes});
    assign trial_diff = trial - {1'b0, blk_bytes};
    assign quo_ok     = (quo_reg < ADDR_W'(cnt));

    always_comb begin
        status          = '0;
        status.mode     = mode_reg;
        status.scan_end = scan_end;
        status.scan_hit = !scan_end && free_map_reg[idx_reg[IDX_W-1:0]];
        status.in_range = (addr_reg != '0) && (addr_reg >= base_addr)
                          && (LIM_W'(addr_reg) < limit);
        status.div_done = (div_cnt_reg == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS));
        status.out_full = m_valid_reg && !m_tready;
    end

    // free map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_map_reg <= '0;
        end else if (cmd.init_map) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (32'(i) < 32'(cnt)) free_map_reg[i] <= 1'b1;
            end
        end else if (cmd.alloc_commit) begin
            free_map_reg[idx_reg[IDX_W-1:0]] <= 1'b0;
        end else if (cmd.free_commit && quo_ok) begin
            free_map_reg[quo_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg     <= fbpa_pkg::mode_t'(s_mode);
            addr_reg     <= s_address;
            idx_reg      <= '0;
            res_addr_reg <= '0;
            res_ok_reg   <= 1'b0;
        end
        if (cmd.scan_step) idx_reg <= idx_reg + CNT_W'(1);
        if (cmd.mul_idx || cmd.mul_cnt) prod_reg <= product;
        if (cmd.alloc_commit) begin
            res_addr_reg <= base_addr + ADDR_W'(prod_reg);
            res_ok_reg   <= 1'b1;
        end
        if (cmd.div_start) begin
            rem_reg     <= '0;
            quo_reg     <= addr_reg - base_addr;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= trial_take ? trial_diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            quo_reg     <= {quo_reg[ADDR_W-2:0], trial_take};
            div_cnt_reg <= div_cnt_reg + fbpa_pkg::DIV_CNT_W'(1);
        end
        if (cmd.free_commit) res_ok_reg <= quo_ok;
    end

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_addr_reg <= res_addr_reg;
            m_ok_reg   <= res_ok_reg;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_block_address = m_addr_reg;
    assign m_ok            = m_ok_reg;

    a_free_only_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.free_commit |=> (($past(free_map_reg) & ~free_map_reg) == '0))
        else $error("fbpa_dp: free cleared a block bit");

    a_alloc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |=> res_ok_reg)
        else $error("fbpa_dp: allocation without ok");

    a_alloc_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |-> (idx_reg < cnt))
        else $error("fbpa_dp: allocated block outside the pool");

endmodule

`default_nettype wire

// ----- sim/fbpa_pool_checker.sv -----
// fbpa_pool_checker: watches the request, result and register ports of the pool allocator,
// predicts every result beat from its own copy of the pool state and compares field by field
// depends on fbpa_pkg
module fbpa_pool_checker #(
    parameter int POOL_MAX = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // address
    input  wire logic [1:0]  s_tuser,   // mode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // block_address
    input  wire logic        m_tuser,   // ok
    input  wire logic        cfg_wen,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [31:0] block_address;
        logic        ok;
    } pool_result_t;

    // own view of the registers and the free map
    logic [31:0]         base_q;
    logic [15:0]         bytes_q;
    logic [5:0]          count_q;
    logic [POOL_MAX-1:0] free_blocks;

    pool_result_t pending_results[$];
    pool_result_t predicted;
    pool_result_t oldest;
    int           mismatch_count = 0;
    int           pending_count  = 0;
    int           results_seen   = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string msg);
        $display("%s", msg);
        mismatch_count++;
    endtask

    // one request against the pool, updating the free map
    task automatic apply_pool_request(input fbpa_pkg::mode_t op, input logic [31:0] addr,
                                      output pool_result_t res);
        int          cnt;
        logic        found;
        logic [63:0] limit;
        logic [31:0] idx;
        res   = '0;
        found = 1'b0;
        cnt   = (count_q > POOL_MAX) ? POOL_MAX : int'(count_q);
        case (op)
            fbpa_pkg::MODE_INIT: begin
                for (int i = 0; i < cnt; i++)
                    free_blocks[i] = 1'b1;
            end
            fbpa_pkg::MODE_ALLOC: begin
                for (int i = 0; i < cnt; i++) begin
                    if (!found && free_blocks[i]) begin
                        found               = 1'b1;
                        free_blocks[i]      = 1'b0;
                        res.block_address   = base_q + (32'(i) * {16'd0, bytes_q});
                        res.ok              = 1'b1;
                    end
                end
            end
            fbpa_pkg::MODE_FREE: begin
                limit = {32'd0, base_q} + {48'd0, bytes_q} * 64'(cnt);
                if (addr != 32'd0 && addr >= base_q && {32'd0, addr} < limit) begin
                    idx = (addr - base_q) / {16'd0, bytes_q};
                    if (idx < 32'(cnt)) begin
                        free_blocks[idx] = 1'b1;
                        res.ok           = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            base_q      = '0;
            bytes_q     = '0;
            count_q     = '0;
            free_blocks = '0;
            pending_results.delete();
            pending_count <= 0;
        end else begin
            if (cfg_wen) begin
                case (fbpa_pkg::cfg_index_t'(cfg_index))
                    fbpa_pkg::CFG_BASE_ADDR: base_q  = cfg_wdata;
                    fbpa_pkg::CFG_BLK_BYTES: bytes_q = cfg_wdata[15:0];
                    fbpa_pkg::CFG_BLK_COUNT: count_q = cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_pool_request(fbpa_pkg::mode_t'(s_tuser), s_tdata, predicted);
                pending_results.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d: unexpected beat, address 0x%08h ok %0b",
                                              results_seen, m_tdata, m_tuser));
                end else begin
                    oldest = pending_results.pop_front();
                    if (m_tdata !== oldest.block_address)
                        report_mismatch($sformatf("result %0d: block_address 0x%08h, want 0x%08h",
                                                  results_seen, m_tdata, oldest.block_address));
                    if (m_tuser !== oldest.ok)
                        report_mismatch($sformatf("result %0d: ok %0b, want %0b",
                                                  results_seen, m_tuser, oldest.ok));
                end
            end
            pending_count <= pending_results.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// testbench: stimulus and verdict for fixed_block_pool_allocator
// depends on fbpa_pkg, fixed_block_pool_allocator and fbpa_pool_checker
module testbench;

    localparam int POOL_MAX    = 32;
    localparam int STALL_LIMIT = 3000;   // idle cycles tolerated before giving up
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int PHASES      = 14;
    localparam int PHASE_BEATS = 50;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int stall_cycles = 0;

    // idling switches, changed per phase
    logic tx_idle_on    = 1'b1;
    logic rx_idle_on    = 1'b1;
    logic hold_off_req  = 1'b0;

    // register values as last written, used to aim free addresses at the pool
    logic [31:0] cur_base = '0;
    logic [15:0] cur_size = '0;
    logic [5:0]  cur_num  = '0;

    always #5 aclk = ~aclk;

    fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_MAX)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fbpa_pool_checker #(.POOL_MAX(POOL_MAX)) pool_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // one register write per edge; the caller drops cfg_wen after the last one,
    // so back-to-back writes never lower and raise the enable in one step
    task automatic write_reg(input fbpa_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            fbpa_pkg::CFG_BASE_ADDR: cur_base = val;
            fbpa_pkg::CFG_BLK_BYTES: cur_size = val[15:0];
            fbpa_pkg::CFG_BLK_COUNT: cur_num  = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [15:0] size,
                            input logic [5:0] num);
        write_reg(fbpa_pkg::CFG_BASE_ADDR, base);
        write_reg(fbpa_pkg::CFG_BLK_BYTES, {16'd0, size});
        write_reg(fbpa_pkg::CFG_BLK_COUNT, {26'd0, num});
        cfg_wen <= 1'b0;
    endtask

    // request beat; tvalid is only touched once per step, so a zero gap keeps it high
    task automatic send_request(input fbpa_pkg::mode_t op, input logic [31:0] addr);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // wait for every predicted result to come back; the extra edge lets the
    // checker count catch up with the beat just accepted
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // mostly addresses inside the pool (any byte of a block), plus the first
    // address past the end, one below the base, zero and plain noise
    function automatic logic [31:0] pick_free_address();
        int          cnt;
        int          r;
        logic [31:0] idx;
        logic [31:0] offs;
        cnt  = (cur_num > POOL_MAX) ? POOL_MAX : int'(cur_num);
        r    = $urandom_range(0, 99);
        offs = (cur_size > 0) ? $urandom_range(0, cur_size - 1) : 32'd0;
        if (r < 62) begin
            idx = (cnt > 0) ? $urandom_range(0, cnt - 1) : 32'd0;
            return cur_base + idx * {16'd0, cur_size} + offs;
        end else if (r < 72) begin
            return cur_base + 32'(cnt) * {16'd0, cur_size};
        end else if (r < 80) begin
            return cur_base - 32'd1;
        end else if (r < 86) begin
            return 32'd0;
        end
        return $urandom;
    endfunction

    // result side: random stalls per beat, plus one long hold-off on request
    initial begin
        int w;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                // keep the result back long enough for the input side to back up
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                w = 0;
            end else begin
                w = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // watchdog: cycles with no beat and no register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          r;
        logic [31:0] base;
        logic [15:0] size;
        logic [5:0]  num;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: empty pool, zero range
        send_request(fbpa_pkg::MODE_ALLOC, $urandom);
        send_request(fbpa_pkg::MODE_INIT, $urandom);
        send_request(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFF);
        send_request(fbpa_pkg::MODE_NONE, $urandom);
        drain_results();

        // small pool of three blocks; the unused register index is written too
        write_reg(fbpa_pkg::CFG_UNUSED, $urandom);
        set_pool(32'h0000_1000, 16'h0040, 6'd3);
        send_request(fbpa_pkg::MODE_INIT, 32'h0);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);
        send_request(fbpa_pkg::MODE_ALLOC, $urandom);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);           // pool exhausted
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_1040);    // block start
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_1081);    // inside a block
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_1081);    // block already free
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_0FFF);    // just below the base
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_10C0);    // first address past the pool
        send_request(fbpa_pkg::MODE_FREE, 32'h0);            // null address
        send_request(fbpa_pkg::MODE_NONE, 32'hFFFF_FFFF);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);
        drain_results();

        // zero block size: free always rejected, alloc still hands out the base
        write_reg(fbpa_pkg::CFG_BLK_BYTES, 32'h0);
        cfg_wen <= 1'b0;
        send_request(fbpa_pkg::MODE_FREE, 32'h0000_1000);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);
        drain_results();

        // top of the address space, largest blocks, block count saturating
        set_pool(32'hFFFF_FFFF, 16'hFFFF, 6'd63);
        send_request(fbpa_pkg::MODE_INIT, 32'h0);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);
        send_request(fbpa_pkg::MODE_ALLOC, 32'h0);           // address wraps past zero
        send_request(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFF);
        send_request(fbpa_pkg::MODE_FREE, 32'hFFFF_FFFE);
        drain_results();

        // random phases: new pool layout each time, then init and a mix of requests
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: base = 32'h0;
                1: base = $urandom_range(1, 255) << 8;
                2: base = $urandom;
                3: base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                default: base = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 4))
                0: size = 16'h0;
                1: size = 16'h1;
                2: size = 16'($urandom_range(2, 256));
                3: size = 16'($urandom_range(0, 65535));
                default: size = 16'hFFFF;
            endcase
            case ($urandom_range(0, 4))
                0: num = 6'd0;
                1: num = 6'($urandom_range(1, 8));
                2: num = 6'($urandom_range(1, 32));
                3: num = 6'd32;
                default: num = 6'($urandom_range(33, 63));
            endcase
            // some phases run without gaps on one or both sides
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 3) begin
                tx_idle_on   = 1'b0;
                hold_off_req = 1'b1;
            end
            set_pool(base, size, num);
            send_request(fbpa_pkg::MODE_INIT, $urandom);
            for (int n = 1; n < PHASE_BEATS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_request(fbpa_pkg::MODE_INIT, $urandom);
                else if (r < 50)
                    send_request(fbpa_pkg::MODE_ALLOC, $urandom);
                else if (r < 93)
                    send_request(fbpa_pkg::MODE_FREE, pick_free_address());
                else
                    send_request(fbpa_pkg::MODE_NONE, $urandom);
            end
            drain_results();
        end

        // settle time for anything stray to show up
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
